FILE: rtl/core/css_pkg.sv
// Shared types and codes for the compacting segment store.
package css_pkg;

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_DELVAL = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_DELSEG = 3'd4;
   localparam logic [2:0] OP_RESIZE = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ROOM     = 3'd1;
   localparam logic [2:0] ST_UNKNOWN  = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_LOOK,
      S_DISPATCH,
      S_SCAN,
      S_ZERO,
      S_SHIFT,
      S_MARK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [15:0]        segment_id;
      logic signed [31:0] value;
      logic [5:0]         slot_index;
      logic               auto_slot;
      logic [6:0]         seg_size;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] new_id;
      logic [6:0]  free_words;
   } rsp_type;

endpackage

FILE: rtl/core/css_ram.sv
// Simple dual-port synchronous memory with registered read data.
module css_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/css_ctrl.sv
// Sequencer that locates segments, scans slots and moves words in the two memories.
module css_ctrl #(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32,
   parameter int ID_WIDTH   = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  css_pkg::req_type                             req_data,
   output logic                                         res_valid,
   input  logic                                         res_ready,
   output css_pkg::rsp_type                             res_data,
   output logic [$clog2(DEPTH)-1:0]                     raddr,
   output logic [$clog2(DEPTH)-1:0]                     waddr,
   output logic                                         d_we,
   output logic [WORD_WIDTH-1:0]                        d_wdata,
   input  logic [WORD_WIDTH-1:0]                        d_rdata,
   output logic                                         m_we,
   output logic [$clog2(DEPTH+1)+ID_WIDTH-1:0]          m_wdata,
   input  logic [$clog2(DEPTH+1)+ID_WIDTH-1:0]          m_rdata
);
   import css_pkg::*;

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int MW  = CW + ID_WIDTH;
   localparam int XW  = ((CW > 7) ? CW : 7) + 2;
   localparam int IXW = (ID_WIDTH > 16) ? ID_WIDTH : 16;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [ID_WIDTH-1:0] next_id_ff, next_id_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [CW-1:0]       size_ff, size_in;
   logic [ID_WIDTH-1:0] idp1_ff, idp1_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic                pv_ff, pv_in;
   logic [AW-1:0]       pa_ff, pa_in;
   logic                pc_ff, pc_in;
   logic                up_ff, up_in;
   logic [CW-1:0]       dist_ff, dist_in;
   logic [CW-1:0]       lim_ff, lim_in;
   logic [2:0]          status_ff, status_in;
   logic [15:0]         nid_ff, nid_in;

   logic [63:0]           val_ext;
   logic [WORD_WIDTH-1:0] word;
   logic [CW-1:0]         r_size;
   logic [ID_WIDTH-1:0]   r_idp1;
   logic                  id_hit;
   logic [CW-1:0]         room_at;
   logic [XW-1:0]         seg_end;
   logic [XW-1:0]         new_end;
   logic [XW-1:0]         fill_resized;
   logic [XW-1:0]         slot_addr;
   logic                  copy_now;
   logic [XW-1:0]         src_addr;
   logic                  scan_hit;

   assign val_ext      = {32'b0, req_ff.value};
   assign word         = val_ext[WORD_WIDTH-1:0];
   assign r_size       = m_rdata[MW-1:ID_WIDTH];
   assign r_idp1       = m_rdata[ID_WIDTH-1:0];
   assign id_hit       = (r_size != '0) && (r_idp1 != '0) &&
                         (IXW'(r_idp1 - ID_WIDTH'(1)) == IXW'(req_ff.segment_id));
   assign room_at      = CW'(DEPTH) - CW'(pa_ff);
   assign seg_end      = XW'(base_ff) + XW'(size_ff);
   assign new_end      = XW'(base_ff) + XW'(req_ff.seg_size);
   assign fill_resized = XW'(fill_ff) + XW'(req_ff.seg_size) - XW'(size_ff);
   assign slot_addr    = XW'(base_ff) + XW'(req_ff.slot_index);
   assign copy_now     = up_ff ? (XW'(ptr_ff) >= XW'(lim_ff)) : (XW'(ptr_ff) < XW'(lim_ff));
   assign src_addr     = up_ff ? (XW'(ptr_ff) - XW'(dist_ff)) : (XW'(ptr_ff) + XW'(dist_ff));
   assign scan_hit     = (req_ff.op == OP_ADD) ? (d_rdata == '0) : (d_rdata == word);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         fill_ff    <= '0;
         next_id_ff <= '0;
         cnt_ff     <= CW'(DEPTH);
         ptr_ff     <= '0;
         pv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         next_id_ff <= next_id_in;
         cnt_ff     <= cnt_in;
         ptr_ff     <= ptr_in;
         pv_ff      <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      base_ff   <= base_in;
      size_ff   <= size_in;
      idp1_ff   <= idp1_in;
      pa_ff     <= pa_in;
      pc_ff     <= pc_in;
      up_ff     <= up_in;
      dist_ff   <= dist_in;
      lim_ff    <= lim_in;
      status_ff <= status_in;
      nid_ff    <= nid_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      fill_in    = fill_ff;
      next_id_in = next_id_ff;
      base_in    = base_ff;
      size_in    = size_ff;
      idp1_in    = idp1_ff;
      cnt_in     = cnt_ff;
      ptr_in     = ptr_ff;
      pv_in      = 1'b0;
      pa_in      = pa_ff;
      pc_in      = pc_ff;
      up_in      = up_ff;
      dist_in    = dist_ff;
      lim_in     = lim_ff;
      status_in  = status_ff;
      nid_in     = nid_ff;
      raddr      = ptr_ff;
      waddr      = pa_ff;
      d_we       = 1'b0;
      d_wdata    = '0;
      m_we       = 1'b0;
      m_wdata    = '0;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      case (state_ff)
         S_INIT: begin
            d_we   = 1'b1;
            m_we   = 1'b1;
            waddr  = ptr_ff;
            ptr_in = ptr_ff + AW'(1);
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in    = req_data;
               status_in = ST_OK;
               nid_in    = '0;
               ptr_in    = '0;
               cnt_in    = CW'(DEPTH);
               case (req_data.op)
                  OP_CREATE: begin
                     if ((req_data.seg_size == '0) ||
                         (XW'(req_data.seg_size) > XW'(DEPTH) - XW'(fill_ff)) ||
                         (next_id_ff == '1)) begin
                        status_in = ST_ROOM;
                        state_in  = S_RESP;
                     end else begin
                        ptr_in   = AW'(fill_ff);
                        cnt_in   = CW'(req_data.seg_size);
                        nid_in   = 16'(next_id_ff);
                        state_in = S_ZERO;
                     end
                  end
                  OP_ADD, OP_DELVAL, OP_CLEAR, OP_DELSEG, OP_RESIZE: begin
                     state_in = S_LOOK;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_LOOK: begin
            if (cnt_ff != '0) begin
               pv_in  = 1'b1;
               pa_in  = ptr_ff;
               ptr_in = ptr_ff + AW'(1);
               cnt_in = cnt_ff - CW'(1);
            end
            if (pv_ff && id_hit) begin
               pv_in    = 1'b0;
               base_in  = pa_ff;
               idp1_in  = r_idp1;
               size_in  = (r_size > room_at) ? room_at : r_size;
               state_in = S_DISPATCH;
            end else if (!pv_ff && (cnt_ff == '0)) begin
               status_in = ST_UNKNOWN;
               state_in  = S_RESP;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            case (req_ff.op)
               OP_ADD, OP_CLEAR: begin
                  if ((req_ff.op == OP_ADD) && req_ff.auto_slot) begin
                     ptr_in   = base_ff;
                     cnt_in   = size_ff;
                     state_in = S_SCAN;
                  end else if (XW'(req_ff.slot_index) >= XW'(size_ff)) begin
                     status_in = ST_RANGE;
                  end else begin
                     d_we    = 1'b1;
                     waddr   = AW'(slot_addr);
                     d_wdata = (req_ff.op == OP_ADD) ? word : '0;
                  end
               end
               OP_DELVAL: begin
                  ptr_in   = base_ff;
                  cnt_in   = size_ff;
                  state_in = S_SCAN;
               end
               OP_DELSEG: begin
                  fill_in  = (fill_ff >= size_ff) ? (fill_ff - size_ff) : '0;
                  up_in    = 1'b0;
                  dist_in  = size_ff;
                  lim_in   = CW'(DEPTH) - size_ff;
                  ptr_in   = base_ff;
                  cnt_in   = CW'(DEPTH) - CW'(base_ff);
                  state_in = S_SHIFT;
               end
               OP_RESIZE: begin
                  if ((req_ff.seg_size == '0) || (fill_resized > XW'(DEPTH))) begin
                     status_in = ST_ROOM;
                  end else if (XW'(req_ff.seg_size) > XW'(size_ff)) begin
                     fill_in  = CW'(fill_resized);
                     up_in    = 1'b1;
                     dist_in  = CW'(req_ff.seg_size) - size_ff;
                     lim_in   = CW'(new_end);
                     ptr_in   = AW'(DEPTH - 1);
                     cnt_in   = CW'(XW'(DEPTH) - seg_end);
                     state_in = S_SHIFT;
                  end else if (XW'(req_ff.seg_size) < XW'(size_ff)) begin
                     fill_in  = CW'(fill_resized);
                     up_in    = 1'b0;
                     dist_in  = size_ff - CW'(req_ff.seg_size);
                     lim_in   = CW'(DEPTH) - (size_ff - CW'(req_ff.seg_size));
                     ptr_in   = AW'(new_end);
                     cnt_in   = CW'(XW'(DEPTH) - new_end);
                     state_in = S_SHIFT;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SCAN: begin
            if (cnt_ff != '0) begin
               pv_in  = 1'b1;
               pa_in  = ptr_ff;
               ptr_in = ptr_ff + AW'(1);
               cnt_in = cnt_ff - CW'(1);
            end
            if (pv_ff && scan_hit) begin
               pv_in     = 1'b0;
               d_we      = 1'b1;
               waddr     = pa_ff;
               d_wdata   = (req_ff.op == OP_ADD) ? word : '0;
               status_in = ST_OK;
               state_in  = S_RESP;
            end else if (!pv_ff && (cnt_ff == '0)) begin
               status_in = (req_ff.op == OP_ADD) ? ST_FULL : ST_NOTFOUND;
               state_in  = S_RESP;
            end
         end
         S_ZERO: begin
            d_we  = 1'b1;
            m_we  = 1'b1;
            waddr = ptr_ff;
            if (ptr_ff == AW'(fill_ff)) begin
               m_wdata = {CW'(req_ff.seg_size), next_id_ff + ID_WIDTH'(1)};
            end
            ptr_in = ptr_ff + AW'(1);
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               fill_in    = fill_ff + CW'(req_ff.seg_size);
               next_id_in = next_id_ff + ID_WIDTH'(1);
               state_in   = S_RESP;
            end
         end
         S_SHIFT: begin
            if (cnt_ff != '0) begin
               raddr  = AW'(src_addr);
               pv_in  = 1'b1;
               pa_in  = ptr_ff;
               pc_in  = copy_now;
               ptr_in = up_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
               cnt_in = cnt_ff - CW'(1);
            end
            if (pv_ff) begin
               d_we    = 1'b1;
               m_we    = 1'b1;
               waddr   = pa_ff;
               d_wdata = pc_ff ? d_rdata : '0;
               m_wdata = pc_ff ? m_rdata : '0;
            end
            if (!pv_ff && (cnt_ff == '0)) begin
               state_in = (req_ff.op == OP_RESIZE) ? S_MARK : S_RESP;
            end
         end
         S_MARK: begin
            m_we     = 1'b1;
            waddr    = base_ff;
            m_wdata  = {CW'(req_ff.seg_size), idp1_ff};
            state_in = S_RESP;
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res_data.status     = status_ff;
      res_data.new_id     = nid_ff;
      res_data.free_words = 7'(XW'(DEPTH) - XW'(fill_ff));
   end

endmodule

FILE: rtl/core/compacting_segment_store.sv
// Top level of the compacting segment store with its memories and result register.
// Create zeroes the words of the new segment; other ops first locate the segment and
// then scan or move words.
// Throughput: one item at a time; the single read and write port of each memory sets
// the pace of the locate scan and of the compaction pass, one word per cycle.
// Reset: synchronous; a clearing pass over all DEPTH words zeroes both memories before the
// first item is accepted.
module compacting_segment_store #(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32,
   parameter int ID_WIDTH   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  css_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output css_pkg::rsp_type rsp_data
);
   import css_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int MW = $clog2(DEPTH + 1) + ID_WIDTH;

   logic                  ctl_res_valid;
   logic                  ctl_res_ready;
   rsp_type               ctl_res_data;
   logic [AW-1:0]         raddr;
   logic [AW-1:0]         waddr;
   logic                  d_we;
   logic [WORD_WIDTH-1:0] d_wdata;
   logic [WORD_WIDTH-1:0] d_rdata;
   logic                  m_we;
   logic [MW-1:0]         m_wdata;
   logic [MW-1:0]         m_rdata;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   css_ctrl #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .ID_WIDTH   (ID_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (ctl_res_valid),
      .res_ready (ctl_res_ready),
      .res_data  (ctl_res_data),
      .raddr     (raddr),
      .waddr     (waddr),
      .d_we      (d_we),
      .d_wdata   (d_wdata),
      .d_rdata   (d_rdata),
      .m_we      (m_we),
      .m_wdata   (m_wdata),
      .m_rdata   (m_rdata)
   );

   css_ram #(
      .DEPTH (DEPTH),
      .WIDTH (WORD_WIDTH)
   ) u_data_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (waddr),
      .wdata (d_wdata),
      .raddr (raddr),
      .rdata (d_rdata)
   );

   css_ram #(
      .DEPTH (DEPTH),
      .WIDTH (MW)
   ) u_mark_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (waddr),
      .wdata (m_wdata),
      .raddr (raddr),
      .rdata (m_rdata)
   );

   assign ctl_res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl_res_valid && ctl_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ctl_res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      ctl_res_valid |-> !req_ready)
      else $error("input accepted while a result is pending in the sequencer");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer did not leave idle after accepting an item");

   a_rsp_from_ctrl: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl_res_valid))
      else $error("result register loaded without a sequencer result");

   a_new_id_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.new_id != '0)) |-> (rsp_data.status == ST_OK))
      else $error("nonzero new id reported with a failing status");

endmodule

FILE: test/compacting_segment_store_checker.sv
// Checker that predicts and compares the results of the compacting segment store.
module compacting_segment_store_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  css_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  css_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   import css_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;

   logic [31:0] words[DEPTH];
   logic [6:0]  sizes[DEPTH];
   logic [15:0] ids_plus_one[DEPTH];
   int unsigned used_words;
   logic [15:0] id_counter;
   rsp_type     expected_results[$];

   function automatic int find_segment(logic [15:0] id);
      for (int i = 0; i < DEPTH; i++) begin
         if (sizes[i] != 0 && ids_plus_one[i] != 0 && ids_plus_one[i] - 16'd1 == id) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void clear_word(int a);
      words[a] = '0;
      sizes[a] = '0;
      ids_plus_one[a] = '0;
   endfunction

   function automatic void compact_down(int dst, int src);
      int d;
      d = src - dst;
      for (int j = dst; j + d < DEPTH; j++) begin
         words[j] = words[j + d];
         sizes[j] = sizes[j + d];
         ids_plus_one[j] = ids_plus_one[j + d];
      end
      for (int j = DEPTH - d; j < DEPTH; j++) clear_word(j);
   endfunction

   function automatic void open_gap(int src, int dst);
      int d;
      d = dst - src;
      for (int i = DEPTH; i > dst; i--) begin
         words[i - 1] = words[i - 1 - d];
         sizes[i - 1] = sizes[i - 1 - d];
         ids_plus_one[i - 1] = ids_plus_one[i - 1 - d];
      end
      for (int i = src; i < dst; i++) clear_word(i);
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type res;
      int loc, base, size, req;
      logic [2:0] op;
      logic [31:0] v;
      logic found;
      res = '0;
      op = r.op;
      v = r.value;
      req = r.seg_size;
      base = 0;
      size = 0;
      if (op >= OP_ADD && op <= OP_RESIZE) begin
         loc = find_segment(r.segment_id);
         if (loc < 0) begin
            res.status = ST_UNKNOWN;
            op = 3'd7;
         end else begin
            base = loc;
            size = sizes[base];
            if (base + size > DEPTH) size = DEPTH - base;
         end
      end
      case (op)
         OP_CREATE: begin
            if (req == 0 || req > DEPTH - used_words || id_counter == 16'hFFFF) begin
               res.status = ST_ROOM;
            end else begin
               for (int i = used_words; i < used_words + req; i++) clear_word(i);
               sizes[used_words] = req[6:0];
               ids_plus_one[used_words] = id_counter + 16'd1;
               res.new_id = id_counter;
               id_counter++;
               used_words += req;
            end
         end
         OP_ADD: begin
            if (r.auto_slot) begin
               found = 1'b0;
               for (int i = 0; i < size && !found; i++) begin
                  if (words[base + i] == 0) begin
                     words[base + i] = v;
                     found = 1'b1;
                  end
               end
               res.status = found ? ST_OK : ST_FULL;
            end else if (r.slot_index >= size) begin
               res.status = ST_RANGE;
            end else begin
               words[base + r.slot_index] = v;
            end
         end
         OP_DELVAL: begin
            found = 1'b0;
            for (int i = 0; i < size && !found; i++) begin
               if (words[base + i] == v) begin
                  words[base + i] = '0;
                  found = 1'b1;
               end
            end
            res.status = found ? ST_OK : ST_NOTFOUND;
         end
         OP_CLEAR: begin
            if (r.slot_index >= size) res.status = ST_RANGE;
            else words[base + r.slot_index] = '0;
         end
         OP_DELSEG: begin
            sizes[base] = '0;
            ids_plus_one[base] = '0;
            if (size > 0) compact_down(base, base + size);
            used_words = (used_words >= size) ? used_words - size : 0;
         end
         OP_RESIZE: begin
            if (req == 0 || used_words - size + req > DEPTH) begin
               res.status = ST_ROOM;
            end else if (req > size) begin
               open_gap(base + size, base + req);
               sizes[base] = req[6:0];
               used_words = used_words - size + req;
            end else if (req < size) begin
               compact_down(base + req, base + size);
               sizes[base] = req[6:0];
               used_words = used_words - size + req;
            end
         end
         default: ;
      endcase
      res.free_words = 7'(DEPTH - used_words);
      return res;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) clear_word(i);
         used_words = 0;
         id_counter = '0;
         fail_count <= 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("Unexpected result %p", rsp_data);
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("Mismatch: expected %p, got %p", want, rsp_data);
                  end
               end
            end
         end
         if (req_valid && req_ready) expected_results.push_back(apply_request(req_data));
      end
   end
endmodule

FILE: test/compacting_segment_store_tb.sv
// Top of the compacting segment store testbench: clock, reset, stimulus and verdict.
module compacting_segment_store_tb;
   import css_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      quiet_cycles = 0;
   logic [15:0] live_ids[$];
   logic [15:0] next_seg = '0;

   always #2 clock = ~clock;

   compacting_segment_store u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   compacting_segment_store_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (r.op == OP_CREATE && r.seg_size != 0) begin
         live_ids.push_back(next_seg);
         next_seg++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic req_type make_item(logic [2:0] op, logic [15:0] id, logic [31:0] v,
                                          logic [5:0] idx, logic a, logic [6:0] sz);
      req_type r;
      r.op = op;
      r.segment_id = id;
      r.value = v;
      r.slot_index = idx;
      r.auto_slot = a;
      r.seg_size = sz;
      return r;
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(5))
         0: return '0;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'(1 + $urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_item();
      logic [15:0] id;
      logic [6:0] sz;
      if (live_ids.size() > 0 && $urandom_range(9) != 0) begin
         id = live_ids[$urandom_range(live_ids.size() - 1)];
      end else begin
         id = 16'($urandom);
      end
      sz = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 12));
      return make_item(3'($urandom_range($urandom_range(7) == 0 ? 7 : 5)), id,
                       random_value(), 6'($urandom_range(($urandom_range(4) == 0) ? 63 : 12)),
                       1'($urandom), sz);
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(make_item(OP_CREATE, '0, '0, '0, 1'b0, 7'd0));
      send_item(make_item(OP_CREATE, '0, '0, '0, 1'b0, 7'd65));
      send_item(make_item(OP_CREATE, '0, '0, '0, 1'b0, 7'd4));
      send_item(make_item(OP_CREATE, '0, '0, '0, 1'b0, 7'd3));
      send_item(make_item(OP_ADD, 16'd0, 32'h8000_0000, 6'd0, 1'b0, '0));
      send_item(make_item(OP_ADD, 16'd0, 32'h7FFF_FFFF, 6'd63, 1'b1, '0));
      send_item(make_item(OP_ADD, 16'd0, 32'hFFFF_FFFF, '0, 1'b1, '0));
      send_item(make_item(OP_ADD, 16'd0, 32'd5, '0, 1'b1, '0));
      send_item(make_item(OP_ADD, 16'd0, 32'd6, '0, 1'b1, '0));
      send_item(make_item(OP_ADD, 16'd0, 32'd6, 6'd4, 1'b0, '0));
      send_item(make_item(OP_ADD, 16'hFFFF, 32'd1, '0, 1'b0, '0));
      send_item(make_item(OP_DELVAL, 16'd0, 32'd9, '0, 1'b0, '0));
      send_item(make_item(OP_DELVAL, 16'd0, 32'd5, '0, 1'b0, '0));
      send_item(make_item(OP_DELVAL, 16'd0, 32'd0, '0, 1'b0, '0));
      send_item(make_item(OP_CLEAR, 16'd0, '0, 6'd63, 1'b0, '0));
      send_item(make_item(OP_CLEAR, 16'd0, '0, 6'd1, 1'b0, '0));
      send_item(make_item(OP_RESIZE, 16'd0, '0, '0, 1'b0, 7'd0));
      send_item(make_item(OP_RESIZE, 16'd0, '0, '0, 1'b0, 7'd64));
      send_item(make_item(OP_RESIZE, 16'd0, '0, '0, 1'b0, 7'd4));
      send_item(make_item(OP_RESIZE, 16'd0, '0, '0, 1'b0, 7'd10));
      send_item(make_item(OP_RESIZE, 16'd0, '0, '0, 1'b0, 7'd2));
      send_item(make_item(OP_DELSEG, 16'd1, '0, '0, 1'b0, '0));
      send_item(make_item(OP_CREATE, '0, '0, '0, 1'b0, 7'd62));
      send_item(make_item(3'd6, '0, '0, '0, 1'b0, '0));
      send_item(make_item(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F, 1'b1, 7'h7F));

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 60 : 33) : 0;
         stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 60 : 33) : 0;
         for (int n = 0; n < 356; n++) begin
            if (n == 100) begin
               drain();
            end
            send_item(random_item());
         end
      end

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

FILE: compacting_segment_store.f
rtl/core/css_pkg.sv
rtl/core/css_ram.sv
rtl/core/css_ctrl.sv
rtl/core/compacting_segment_store.sv
test/compacting_segment_store_checker.sv
test/compacting_segment_store_tb.sv
